>>> sv/airl_pkg.sv
// Shared types and constants for the adaptive injection rate limiter.
package airl_pkg;

  // Event codes carried by one input item
  typedef enum logic [2:0] {
    OP_REQUEST     = 3'd0,
    OP_SUCCESS     = 3'd1,
    OP_FAILURE     = 3'd2,
    OP_EPOCH       = 3'd3,
    OP_FORCE_RESET = 3'd4,
    OP_RESET_DONE  = 3'd5,
    OP_SECOND_TICK = 3'd6,
    OP_QUERY       = 3'd7
  } op_t;

  // Health codes as reported on the result channel
  typedef enum logic [2:0] {
    H_HEALTHY   = 3'd0,
    H_DEGRADED  = 3'd1,
    H_COOLDOWN  = 3'd2,
    H_RESETTING = 3'd3,
    H_FAILED    = 3'd4
  } health_t;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_START_RATE         = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_RATE           = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CEILING_RATE       = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RAMP_RUN           = 8'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FAIL_RESET_RUN     = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_BEFORE_REST = 8'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_REST_INTERVAL      = 8'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_REST_DURATION      = 8'd7;

  // Register reset values
  localparam logic [9:0]  RST_START_RATE         = 10'd50;
  localparam logic [9:0]  RST_MIN_RATE           = 10'd5;
  localparam logic [9:0]  RST_CEILING_RATE       = 10'd200;
  localparam logic [15:0] RST_RAMP_RUN           = 16'd100;
  localparam logic [15:0] RST_FAIL_RESET_RUN     = 16'd10;
  localparam logic [31:0] RST_FRAMES_BEFORE_REST = 32'd5000;
  localparam logic [15:0] RST_REST_INTERVAL      = 16'd300;
  localparam logic [15:0] RST_REST_DURATION      = 16'd5;

  // Default tuning
  localparam int unsigned DEF_RAMP_STEP       = 5;
  localparam int unsigned DEF_BACKOFF_DIVISOR = 2;

  // Success average: Q1.15, weight 19/20 on the old value
  localparam logic [15:0] AVG_ONE       = 16'd32768;
  localparam int unsigned AVG_DIV       = 20;
  localparam int unsigned AVG_DIV_SHIFT = 2;   // 20 = 4 * 5
  localparam int unsigned AVG_DIV_ODD   = 5;
  localparam int unsigned AVG_RECIP_K   = 20;
  localparam int unsigned AVG_RECIP_M   = ((1 << AVG_RECIP_K) + AVG_DIV_ODD - 1) / AVG_DIV_ODD;

  // Backoff divider by reciprocal
  localparam int unsigned BK_RECIP_K = 20;

endpackage

>>> sv/adaptive_injection_rate_limiter_top.sv
// Top level of the adaptive injection rate limiter.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one event per item: operation
//    and reset_ok. Result channel (out_valid/out_ready) returns exactly one
//    result item per event: grant, health, rate, flags, average and totals.
//  - Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//    the eight tuning registers; cfg_ready is always high. Write only while
//    no event is in flight.
//  - The result of an event is registered and shown in the cycle after the
//    event is taken. One event per cycle while results are taken; the state
//    update for an event is a single pass of logic between the state and
//    result registers, bounded by the success-average reciprocal multiply.
//  - Reset (rst, synchronous) loads the register defaults, sets the rate to
//    the start rate, the average to 1.0 and clears all counters and totals.
//  - When the receiver stalls, the result register holds its item and
//    in_ready drops until it is taken; in_ready is high whenever the result
//    register is empty or being emptied in the same cycle.
module adaptive_injection_rate_limiter_top #(
  parameter int unsigned RAMP_STEP       = airl_pkg::DEF_RAMP_STEP,
  parameter int unsigned BACKOFF_DIVISOR = airl_pkg::DEF_BACKOFF_DIVISOR
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [airl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data,
  // events
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       operation,
  input  logic                             reset_ok,
  // results
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             granted,
  output logic [2:0]                       health,
  output logic [9:0]                       rate_limit,
  output logic                             rest_scheduled,
  output logic                             reset_request,
  output logic                             cooling,
  output logic [15:0]                      success_average,
  output logic [31:0]                      injected_total,
  output logic [31:0]                      failed_total,
  output logic [31:0]                      throttled_total,
  output logic [31:0]                      resets_total,
  output logic [31:0]                      rests_total
);

  localparam int unsigned BK_M = ((1 << airl_pkg::BK_RECIP_K) + BACKOFF_DIVISOR - 1)
                                 / BACKOFF_DIVISOR;
  localparam int unsigned BK_PW = 10 + airl_pkg::BK_RECIP_K;

  // configuration registers
  logic [9:0]  start_rate, min_rate, ceiling_rate;
  logic [15:0] ramp_run, fail_reset_run, rest_interval, rest_duration;
  logic [31:0] frames_before_rest;

  // block state
  airl_pkg::health_t health_code, health_code_next;
  logic [9:0]  rate_now, rate_now_next;
  logic [9:0]  frames_in_second, frames_in_second_next;
  logic [15:0] ok_run, ok_run_next, fail_run, fail_run_next;
  logic [31:0] frames_since_rest, frames_since_rest_next;
  logic [31:0] seconds_now, seconds_now_next;
  logic [31:0] rest_end, rest_end_next;
  logic [31:0] last_rest_time, last_rest_time_next;
  logic [15:0] ratio_avg, ratio_avg_next;
  logic [31:0] granted_count, granted_count_next;
  logic [31:0] fail_count, fail_count_next;
  logic [31:0] deny_count, deny_count_next;
  logic [31:0] reset_count, reset_count_next;
  logic [31:0] rest_count, rest_count_next;
  logic        reset_by_failure, reset_by_failure_next;

  // per-item result flags
  logic grant_now, sched_now, rreq_now, cool_now;

  // helpers
  airl_pkg::op_t op;
  logic        accept;
  logic        rest_running, rest_due;
  logic [15:0] ok_run_inc, fail_run_inc;
  logic [10:0] ramp_sum;
  logic [9:0]  ramp_rate, backoff_q, backoff_rate;
  logic [BK_PW-1:0] backoff_prod;
  logic [19:0] avg_x;
  logic [17:0] avg_y;
  logic [35:0] avg_prod;
  logic [15:0] avg_q;
  logic [31:0] since_last;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign op        = airl_pkg::op_t'(operation);

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_rate         <= airl_pkg::RST_START_RATE;
      min_rate           <= airl_pkg::RST_MIN_RATE;
      ceiling_rate       <= airl_pkg::RST_CEILING_RATE;
      ramp_run           <= airl_pkg::RST_RAMP_RUN;
      fail_reset_run     <= airl_pkg::RST_FAIL_RESET_RUN;
      frames_before_rest <= airl_pkg::RST_FRAMES_BEFORE_REST;
      rest_interval      <= airl_pkg::RST_REST_INTERVAL;
      rest_duration      <= airl_pkg::RST_REST_DURATION;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        airl_pkg::REG_START_RATE:         start_rate         <= cfg_data[9:0];
        airl_pkg::REG_MIN_RATE:           min_rate           <= cfg_data[9:0];
        airl_pkg::REG_CEILING_RATE:       ceiling_rate       <= cfg_data[9:0];
        airl_pkg::REG_RAMP_RUN:           ramp_run           <= cfg_data[15:0];
        airl_pkg::REG_FAIL_RESET_RUN:     fail_reset_run     <= cfg_data[15:0];
        airl_pkg::REG_FRAMES_BEFORE_REST: frames_before_rest <= cfg_data;
        airl_pkg::REG_REST_INTERVAL:      rest_interval      <= cfg_data[15:0];
        airl_pkg::REG_REST_DURATION:      rest_duration      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // shared arithmetic
  assign rest_running = (rest_end != 32'd0) && (seconds_now < rest_end);
  assign rest_due     = (rest_end != 32'd0) && (seconds_now >= rest_end);
  assign ok_run_inc   = (ok_run == 16'hFFFF) ? ok_run : ok_run + 16'd1;
  assign fail_run_inc = (fail_run == 16'hFFFF) ? fail_run : fail_run + 16'd1;
  assign since_last   = seconds_now - last_rest_time;

  // ramp up by a step, clipped at the ceiling
  assign ramp_sum  = {1'b0, rate_now} + 11'(RAMP_STEP);
  assign ramp_rate = (ramp_sum > {1'b0, ceiling_rate}) ? ceiling_rate : ramp_sum[9:0];

  // back off by the divisor, floored at the minimum
  assign backoff_prod = BK_PW'(rate_now) * BK_PW'(BK_M);
  assign backoff_q    = backoff_prod[BK_PW-1 -: 10];
  assign backoff_rate = (backoff_q < min_rate) ? min_rate : backoff_q;

  // success average: floor(x / 20) as (x >> 2) times reciprocal of 5
  assign avg_x = 20'(ratio_avg) * 20'(airl_pkg::AVG_DIV - 1)
               + ((op == airl_pkg::OP_SUCCESS)
                  ? 20'(airl_pkg::AVG_ONE) + 20'(airl_pkg::AVG_DIV - 1) : 20'd0);
  assign avg_y    = avg_x[19:airl_pkg::AVG_DIV_SHIFT];
  assign avg_prod = 36'(avg_y) * 36'(airl_pkg::AVG_RECIP_M);
  assign avg_q    = avg_prod[35 -: 16];

  // next state for the event at the input
  always_comb begin
    health_code_next       = health_code;
    rate_now_next          = rate_now;
    frames_in_second_next  = frames_in_second;
    ok_run_next            = ok_run;
    fail_run_next          = fail_run;
    frames_since_rest_next = frames_since_rest;
    seconds_now_next       = seconds_now;
    rest_end_next          = rest_end;
    last_rest_time_next    = last_rest_time;
    ratio_avg_next         = ratio_avg;
    granted_count_next     = granted_count;
    fail_count_next        = fail_count;
    deny_count_next        = deny_count;
    reset_count_next       = reset_count;
    rest_count_next        = rest_count;
    reset_by_failure_next  = reset_by_failure;
    grant_now = 1'b0;
    sched_now = 1'b0;
    rreq_now  = 1'b0;
    cool_now  = 1'b0;
    case (op)
      airl_pkg::OP_REQUEST: begin
        if (rest_running) begin
          deny_count_next = deny_count + 32'd1;
        end else begin
          // end a rest that has run out
          if (rest_due) begin
            rest_end_next = 32'd0;
            if (health_code == airl_pkg::H_COOLDOWN) health_code_next = airl_pkg::H_HEALTHY;
          end
          if (health_code_next == airl_pkg::H_RESETTING ||
              health_code_next == airl_pkg::H_FAILED) begin
            deny_count_next = deny_count + 32'd1;
          end else if (frames_in_second >= rate_now) begin
            deny_count_next = deny_count + 32'd1;
          end else begin
            frames_in_second_next = frames_in_second + 10'd1;
            grant_now = 1'b1;
          end
        end
      end
      airl_pkg::OP_SUCCESS: begin
        granted_count_next     = granted_count + 32'd1;
        frames_since_rest_next = frames_since_rest + 32'd1;
        ok_run_next            = ok_run_inc;
        fail_run_next          = 16'd0;
        ratio_avg_next         = avg_q;
        if (ok_run_inc >= ramp_run) begin
          ok_run_next = 16'd0;
          if (rate_now < ceiling_rate) rate_now_next = ramp_rate;
          if (health_code == airl_pkg::H_DEGRADED) health_code_next = airl_pkg::H_HEALTHY;
        end
      end
      airl_pkg::OP_FAILURE: begin
        fail_count_next = fail_count + 32'd1;
        fail_run_next   = fail_run_inc;
        ok_run_next     = 16'd0;
        ratio_avg_next  = avg_q;
        if (fail_run_inc >= fail_reset_run) begin
          health_code_next      = airl_pkg::H_RESETTING;
          fail_run_next         = 16'd0;
          reset_count_next      = reset_count + 32'd1;
          reset_by_failure_next = 1'b1;
          rreq_now              = 1'b1;
        end else if (fail_run_inc >= 16'd2) begin
          rate_now_next    = backoff_rate;
          health_code_next = airl_pkg::H_DEGRADED;
        end
      end
      airl_pkg::OP_EPOCH: begin
        // schedule a pre-emptive rest
        if (frames_since_rest >= frames_before_rest &&
            since_last >= 32'(rest_interval)) begin
          health_code_next       = airl_pkg::H_COOLDOWN;
          rest_end_next          = seconds_now + 32'(rest_duration);
          last_rest_time_next    = seconds_now;
          rest_count_next        = rest_count + 32'd1;
          frames_since_rest_next = 32'd0;
          sched_now              = 1'b1;
        end
      end
      airl_pkg::OP_FORCE_RESET: begin
        health_code_next      = airl_pkg::H_RESETTING;
        reset_count_next      = reset_count + 32'd1;
        reset_by_failure_next = 1'b0;
        rreq_now              = 1'b1;
      end
      airl_pkg::OP_RESET_DONE: begin
        if (health_code == airl_pkg::H_RESETTING) begin
          if (reset_by_failure) begin
            health_code_next = airl_pkg::H_DEGRADED;
          end else begin
            health_code_next = reset_ok ? airl_pkg::H_DEGRADED : airl_pkg::H_FAILED;
            fail_run_next    = 16'd0;
            ok_run_next      = 16'd0;
          end
          rate_now_next          = min_rate;
          frames_since_rest_next = 32'd0;
        end
      end
      airl_pkg::OP_SECOND_TICK: begin
        seconds_now_next      = seconds_now + 32'd1;
        frames_in_second_next = 10'd0;
      end
      airl_pkg::OP_QUERY: begin
        cool_now = (health_code == airl_pkg::H_COOLDOWN) ||
                   (health_code == airl_pkg::H_RESETTING);
        if (rest_due) begin
          rest_end_next = 32'd0;
          if (health_code == airl_pkg::H_COOLDOWN) health_code_next = airl_pkg::H_HEALTHY;
          cool_now = 1'b0;
        end
      end
    endcase
  end

  // update state on an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      health_code       <= airl_pkg::H_HEALTHY;
      rate_now          <= airl_pkg::RST_START_RATE;
      frames_in_second  <= '0;
      ok_run            <= '0;
      fail_run          <= '0;
      frames_since_rest <= '0;
      seconds_now       <= '0;
      rest_end          <= '0;
      last_rest_time    <= '0;
      ratio_avg         <= airl_pkg::AVG_ONE;
      granted_count     <= '0;
      fail_count        <= '0;
      deny_count        <= '0;
      reset_count       <= '0;
      rest_count        <= '0;
      reset_by_failure  <= 1'b0;
    end else if (accept) begin
      health_code       <= health_code_next;
      rate_now          <= rate_now_next;
      frames_in_second  <= frames_in_second_next;
      ok_run            <= ok_run_next;
      fail_run          <= fail_run_next;
      frames_since_rest <= frames_since_rest_next;
      seconds_now       <= seconds_now_next;
      rest_end          <= rest_end_next;
      last_rest_time    <= last_rest_time_next;
      ratio_avg         <= ratio_avg_next;
      granted_count     <= granted_count_next;
      fail_count        <= fail_count_next;
      deny_count        <= deny_count_next;
      reset_count       <= reset_count_next;
      rest_count        <= rest_count_next;
      reset_by_failure  <= reset_by_failure_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // load result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      granted         <= grant_now;
      health          <= health_code_next;
      rate_limit      <= rate_now_next;
      rest_scheduled  <= sched_now;
      reset_request   <= rreq_now;
      cooling         <= cool_now;
      success_average <= ratio_avg_next;
      injected_total  <= granted_count_next;
      failed_total    <= fail_count_next;
      throttled_total <= deny_count_next;
      resets_total    <= reset_count_next;
      rests_total     <= rest_count_next;
    end
  end

endmodule

>>> sv/airl_checker.sv
// Port-level checks for the adaptive injection rate limiter, bound to the top level.
module airl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        granted,
  input logic [2:0]  health,
  input logic [9:0]  rate_limit,
  input logic        rest_scheduled,
  input logic        reset_request,
  input logic [31:0] throttled_total
);

  // hold a stalled result item
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(health) && $stable(rate_limit)
      && $stable(throttled_total))
    else $error("stalled result item changed");

  // every accepted item shows up on the result register next cycle
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // a scheduled rest leaves the block in cooldown
  a_rest_health: assert property (@(posedge clk) disable iff (rst)
    out_valid && rest_scheduled |-> health == airl_pkg::H_COOLDOWN)
    else $error("rest scheduled without cooldown health");

  // a reset request leaves the block resetting
  a_reset_health: assert property (@(posedge clk) disable iff (rst)
    out_valid && reset_request |-> health == airl_pkg::H_RESETTING)
    else $error("reset request without resetting health");

  // no grant while resetting or failed
  a_grant_health: assert property (@(posedge clk) disable iff (rst)
    out_valid && granted |->
      health != airl_pkg::H_RESETTING && health != airl_pkg::H_FAILED)
    else $error("frame granted while interface is down");

endmodule

bind adaptive_injection_rate_limiter_top airl_checker u_airl_checker (.*);

>>> bench/adaptive_injection_rate_limiter_top_tb.sv
// Self-checking testbench for the adaptive injection rate limiter top level.
`timescale 1ns / 100ps

module adaptive_injection_rate_limiter_top_tb;

  localparam int unsigned RAMP_STEP       = airl_pkg::DEF_RAMP_STEP;
  localparam int unsigned BACKOFF_DIVISOR = airl_pkg::DEF_BACKOFF_DIVISOR;
  localparam int unsigned HANG_LIMIT      = 2000;
  localparam int unsigned LONG_HOLD       = 80;

  typedef struct packed {
    airl_pkg::op_t op;
    logic          ok;
  } limiter_event_t;

  typedef struct packed {
    logic        granted;
    logic [2:0]  health;
    logic [9:0]  rate_limit;
    logic        rest_scheduled;
    logic        reset_request;
    logic        cooling;
    logic [15:0] success_average;
    logic [31:0] injected_total;
    logic [31:0] failed_total;
    logic [31:0] throttled_total;
    logic [31:0] resets_total;
    logic [31:0] rests_total;
  } limiter_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [airl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]                      cfg_data  = '0;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  logic [2:0]                       operation = airl_pkg::OP_QUERY;
  logic                             reset_ok  = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             granted;
  logic [2:0]                       health;
  logic [9:0]                       rate_limit;
  logic                             rest_scheduled;
  logic                             reset_request;
  logic                             cooling;
  logic [15:0]                      success_average;
  logic [31:0]                      injected_total;
  logic [31:0]                      failed_total;
  logic [31:0]                      throttled_total;
  logic [31:0]                      resets_total;
  logic [31:0]                      rests_total;

  adaptive_injection_rate_limiter_top #(
    .RAMP_STEP       (RAMP_STEP),
    .BACKOFF_DIVISOR (BACKOFF_DIVISOR)
  ) i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .reset_ok        (reset_ok),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .granted         (granted),
    .health          (health),
    .rate_limit      (rate_limit),
    .rest_scheduled  (rest_scheduled),
    .reset_request   (reset_request),
    .cooling         (cooling),
    .success_average (success_average),
    .injected_total  (injected_total),
    .failed_total    (failed_total),
    .throttled_total (throttled_total),
    .resets_total    (resets_total),
    .rests_total     (rests_total)
  );

  // Clock: 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stimulus and scoreboard storage
  limiter_event_t  event_queue[$];
  limiter_report_t awaited_reports[$];
  int unsigned     queued_count   = 0;
  int unsigned     mismatches     = 0;
  int unsigned     valid_idle_pct = 0;
  int unsigned     ready_idle_pct = 0;
  int unsigned     fail_pct       = 20;
  logic            hold_request   = 1'b0;

  // Shadow copy of the tuning registers
  logic [9:0]  lim_start_rate   = airl_pkg::RST_START_RATE;
  logic [9:0]  lim_min_rate     = airl_pkg::RST_MIN_RATE;
  logic [9:0]  lim_ceiling_rate = airl_pkg::RST_CEILING_RATE;
  logic [15:0] lim_ramp_run     = airl_pkg::RST_RAMP_RUN;
  logic [15:0] lim_fail_run_max = airl_pkg::RST_FAIL_RESET_RUN;
  logic [31:0] lim_rest_frames  = airl_pkg::RST_FRAMES_BEFORE_REST;
  logic [15:0] lim_rest_gap     = airl_pkg::RST_REST_INTERVAL;
  logic [15:0] lim_rest_len     = airl_pkg::RST_REST_DURATION;

  // Shadow copy of the limiter state after reset
  airl_pkg::health_t lim_health = airl_pkg::H_HEALTHY;
  logic [9:0]  lim_rate        = airl_pkg::RST_START_RATE;
  logic [9:0]  lim_frames_sec  = '0;
  logic [15:0] lim_ok_run      = '0;
  logic [15:0] lim_fail_run    = '0;
  logic [31:0] lim_since_rest  = '0;
  logic [31:0] lim_seconds     = '0;
  logic [31:0] lim_rest_end    = '0;
  logic [31:0] lim_last_rest   = '0;
  logic [15:0] lim_avg         = airl_pkg::AVG_ONE;
  logic [31:0] lim_sent        = '0;
  logic [31:0] lim_failed      = '0;
  logic [31:0] lim_denied      = '0;
  logic [31:0] lim_resets      = '0;
  logic [31:0] lim_rests       = '0;
  logic        lim_by_failure  = 1'b0;

  // Close a running rest once its end second has come
  task automatic close_rest_if_due(output logic ended);
    ended = 1'b0;
    if (lim_rest_end != 0 && lim_seconds >= lim_rest_end) begin
      lim_rest_end = '0;
      if (lim_health == airl_pkg::H_COOLDOWN) lim_health = airl_pkg::H_HEALTHY;
      ended = 1'b1;
    end
  endtask

  // Advance the shadow limiter by one event and build its report
  task automatic predict_report(input limiter_event_t ev, output limiter_report_t rep);
    logic        ended;
    logic [31:0] wide;
    rep = '0;
    case (ev.op)
      airl_pkg::OP_REQUEST: begin
        if (lim_rest_end != 0 && lim_seconds < lim_rest_end) begin
          lim_denied++;
        end else begin
          close_rest_if_due(ended);
          if (lim_health == airl_pkg::H_RESETTING || lim_health == airl_pkg::H_FAILED) begin
            lim_denied++;
          end else if (lim_frames_sec >= lim_rate) begin
            lim_denied++;
          end else begin
            lim_frames_sec = lim_frames_sec + 10'd1;
            rep.granted = 1'b1;
          end
        end
      end
      airl_pkg::OP_SUCCESS: begin
        lim_sent++;
        lim_since_rest++;
        if (lim_ok_run != 16'hFFFF) lim_ok_run++;
        lim_fail_run = '0;
        wide = (32'd19 * lim_avg + 32'd32768 + 32'd19) / airl_pkg::AVG_DIV;
        lim_avg = wide[15:0];
        if (lim_ok_run >= lim_ramp_run) begin
          lim_ok_run = '0;
          if (lim_rate < lim_ceiling_rate) begin
            wide = lim_rate + RAMP_STEP;
            lim_rate = (wide > lim_ceiling_rate) ? lim_ceiling_rate : wide[9:0];
          end
          if (lim_health == airl_pkg::H_DEGRADED) lim_health = airl_pkg::H_HEALTHY;
        end
      end
      airl_pkg::OP_FAILURE: begin
        lim_failed++;
        if (lim_fail_run != 16'hFFFF) lim_fail_run++;
        lim_ok_run = '0;
        wide = (32'd19 * lim_avg) / airl_pkg::AVG_DIV;
        lim_avg = wide[15:0];
        if (lim_fail_run >= lim_fail_run_max) begin
          lim_health     = airl_pkg::H_RESETTING;
          lim_fail_run   = '0;
          lim_resets++;
          lim_by_failure = 1'b1;
          rep.reset_request = 1'b1;
        end else if (lim_fail_run >= 16'd2) begin
          lim_rate = 10'(lim_rate / BACKOFF_DIVISOR);
          if (lim_rate < lim_min_rate) lim_rate = lim_min_rate;
          lim_health = airl_pkg::H_DEGRADED;
        end
      end
      airl_pkg::OP_EPOCH: begin
        if (lim_since_rest >= lim_rest_frames &&
            (lim_seconds - lim_last_rest) >= {16'd0, lim_rest_gap}) begin
          lim_health     = airl_pkg::H_COOLDOWN;
          lim_rest_end   = lim_seconds + {16'd0, lim_rest_len};
          lim_last_rest  = lim_seconds;
          lim_rests++;
          lim_since_rest = '0;
          rep.rest_scheduled = 1'b1;
        end
      end
      airl_pkg::OP_FORCE_RESET: begin
        lim_health     = airl_pkg::H_RESETTING;
        lim_resets++;
        lim_by_failure = 1'b0;
        rep.reset_request = 1'b1;
      end
      airl_pkg::OP_RESET_DONE: begin
        if (lim_health == airl_pkg::H_RESETTING) begin
          if (lim_by_failure) begin
            lim_health = airl_pkg::H_DEGRADED;
          end else begin
            lim_health   = ev.ok ? airl_pkg::H_DEGRADED : airl_pkg::H_FAILED;
            lim_fail_run = '0;
            lim_ok_run   = '0;
          end
          lim_rate       = lim_min_rate;
          lim_since_rest = '0;
        end
      end
      airl_pkg::OP_SECOND_TICK: begin
        lim_seconds++;
        lim_frames_sec = '0;
      end
      default: begin
        rep.cooling = (lim_health == airl_pkg::H_COOLDOWN ||
                       lim_health == airl_pkg::H_RESETTING);
        close_rest_if_due(ended);
        if (ended) rep.cooling = 1'b0;
      end
    endcase
    rep.health          = lim_health;
    rep.rate_limit      = lim_rate;
    rep.success_average = lim_avg;
    rep.injected_total  = lim_sent;
    rep.failed_total    = lim_failed;
    rep.throttled_total = lim_denied;
    rep.resets_total    = lim_resets;
    rep.rests_total     = lim_rests;
  endtask

  // Driver: offer queued events, predict each one as it is taken
  always @(posedge clk) begin
    limiter_report_t rep;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_report(limiter_event_t'({operation, reset_ok}), rep);
        awaited_reports.push_back(rep);
      end
      if (!in_valid || in_ready) begin
        if (event_queue.size() > 0 && $urandom_range(99) >= valid_idle_pct) begin
          limiter_event_t ev;
          ev = event_queue.pop_front();
          in_valid  <= 1'b1;
          operation <= ev.op;
          reset_ok  <= ev.ok;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus one long hold when asked
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= ready_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: compare each taken result with the oldest prediction
  always @(posedge clk) begin
    limiter_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_reports.size() == 0) begin
        $error("result item with no prediction waiting");
        mismatches++;
      end else begin
        want = awaited_reports.pop_front();
        check_field("granted", 32'(want.granted), 32'(granted));
        check_field("health", 32'(want.health), 32'(health));
        check_field("rate_limit", 32'(want.rate_limit), 32'(rate_limit));
        check_field("rest_scheduled", 32'(want.rest_scheduled), 32'(rest_scheduled));
        check_field("reset_request", 32'(want.reset_request), 32'(reset_request));
        check_field("cooling", 32'(want.cooling), 32'(cooling));
        check_field("success_average", 32'(want.success_average), 32'(success_average));
        check_field("injected_total", want.injected_total, injected_total);
        check_field("failed_total", want.failed_total, failed_total);
        check_field("throttled_total", want.throttled_total, throttled_total);
        check_field("resets_total", want.resets_total, resets_total);
        check_field("rests_total", want.rests_total, rests_total);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("adaptive_injection_rate_limiter_top_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_event(input airl_pkg::op_t op, input logic ok);
    event_queue.push_back('{op: op, ok: ok});
    queued_count++;
  endtask

  // Write one tuning register and mirror it once taken
  task automatic write_reg(input logic [airl_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      airl_pkg::REG_START_RATE:         lim_start_rate   = data[9:0];
      airl_pkg::REG_MIN_RATE:           lim_min_rate     = data[9:0];
      airl_pkg::REG_CEILING_RATE:       lim_ceiling_rate = data[9:0];
      airl_pkg::REG_RAMP_RUN:           lim_ramp_run     = data[15:0];
      airl_pkg::REG_FAIL_RESET_RUN:     lim_fail_run_max = data[15:0];
      airl_pkg::REG_FRAMES_BEFORE_REST: lim_rest_frames  = data;
      airl_pkg::REG_REST_INTERVAL:      lim_rest_gap     = data[15:0];
      airl_pkg::REG_REST_DURATION:      lim_rest_len     = data[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [9:0] start_r, input logic [9:0] min_r,
                           input logic [9:0] ceil_r, input logic [15:0] ramp,
                           input logic [15:0] fail_max, input logic [31:0] frames,
                           input logic [15:0] gap, input logic [15:0] len);
    write_reg(airl_pkg::REG_START_RATE, {22'd0, start_r});
    write_reg(airl_pkg::REG_MIN_RATE, {22'd0, min_r});
    write_reg(airl_pkg::REG_CEILING_RATE, {22'd0, ceil_r});
    write_reg(airl_pkg::REG_RAMP_RUN, {16'd0, ramp});
    write_reg(airl_pkg::REG_FAIL_RESET_RUN, {16'd0, fail_max});
    write_reg(airl_pkg::REG_FRAMES_BEFORE_REST, frames);
    write_reg(airl_pkg::REG_REST_INTERVAL, {16'd0, gap});
    write_reg(airl_pkg::REG_REST_DURATION, {16'd0, len});
  endtask

  // Wait until every queued event has been taken and every result checked;
  // look at the falling edge so driver and monitor updates have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (event_queue.size() != 0 || in_valid || awaited_reports.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // Random traffic built mostly from well-formed event sequences
  task automatic random_events(input int unsigned count);
    int unsigned first;
    int unsigned burst;
    first = queued_count;
    while (queued_count - first < count) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          // request bursts, each request followed by a success or failure report
          repeat ($urandom_range(1, 8)) begin
            push_event(airl_pkg::OP_REQUEST, 1'($urandom_range(1)));
            push_event(($urandom_range(99) < fail_pct) ? airl_pkg::OP_FAILURE
                                                       : airl_pkg::OP_SUCCESS,
                       1'($urandom_range(1)));
          end
        end
        4: begin
          // failure run, sometimes long enough to ask for an interface reset
          burst = (lim_fail_run_max > 11) ? 12 : lim_fail_run_max + 1;
          repeat ($urandom_range(1, burst))
            push_event(airl_pkg::OP_FAILURE, 1'($urandom_range(1)));
          if ($urandom_range(1)) push_event(airl_pkg::OP_RESET_DONE, 1'($urandom_range(1)));
        end
        5: repeat ($urandom_range(1, 3))
             push_event(airl_pkg::OP_SECOND_TICK, 1'($urandom_range(1)));
        6: begin
          push_event(airl_pkg::OP_EPOCH, 1'($urandom_range(1)));
          push_event(airl_pkg::OP_QUERY, 1'($urandom_range(1)));
        end
        7: begin
          push_event(airl_pkg::OP_FORCE_RESET, 1'($urandom_range(1)));
          if ($urandom_range(1)) push_event(airl_pkg::OP_REQUEST, 1'($urandom_range(1)));
          push_event(airl_pkg::OP_RESET_DONE, 1'($urandom_range(1)));
        end
        8: begin
          push_event(airl_pkg::OP_QUERY, 1'($urandom_range(1)));
          push_event(airl_pkg::OP_REQUEST, 1'($urandom_range(1)));
        end
        default: push_event(airl_pkg::op_t'($urandom_range(7)), 1'($urandom_range(1)));
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Default tuning: grant, backoff, ignored reset done, forced resets
    valid_idle_pct = 6;
    ready_idle_pct = 58;
    push_event(airl_pkg::OP_REQUEST, 1'b0);      push_event(airl_pkg::OP_SUCCESS, 1'b1);
    push_event(airl_pkg::OP_FAILURE, 1'b0);      push_event(airl_pkg::OP_FAILURE, 1'b1);
    push_event(airl_pkg::OP_RESET_DONE, 1'b1);   push_event(airl_pkg::OP_SECOND_TICK, 1'b0);
    push_event(airl_pkg::OP_FORCE_RESET, 1'b0);  push_event(airl_pkg::OP_FORCE_RESET, 1'b1);
    push_event(airl_pkg::OP_REQUEST, 1'b1);      push_event(airl_pkg::OP_QUERY, 1'b0);
    push_event(airl_pkg::OP_RESET_DONE, 1'b0);   push_event(airl_pkg::OP_FORCE_RESET, 1'b0);
    push_event(airl_pkg::OP_RESET_DONE, 1'b1);
    wait_drained();

    // Tight tuning: failure reset, rate floor, ramp to healthy, rest and expiry
    write_all(10'd1023, 10'd1, 10'd1023, 16'd1, 16'd3, 32'd1, 16'd0, 16'd2);
    push_event(airl_pkg::OP_FAILURE, 1'b0);      push_event(airl_pkg::OP_FAILURE, 1'b0);
    push_event(airl_pkg::OP_FAILURE, 1'b1);      push_event(airl_pkg::OP_REQUEST, 1'b0);
    push_event(airl_pkg::OP_RESET_DONE, 1'b0);   push_event(airl_pkg::OP_REQUEST, 1'b1);
    push_event(airl_pkg::OP_REQUEST, 1'b0);      push_event(airl_pkg::OP_SUCCESS, 1'b0);
    push_event(airl_pkg::OP_EPOCH, 1'b1);        push_event(airl_pkg::OP_REQUEST, 1'b0);
    push_event(airl_pkg::OP_SECOND_TICK, 1'b1);  push_event(airl_pkg::OP_SECOND_TICK, 1'b0);
    push_event(airl_pkg::OP_QUERY, 1'b1);        push_event(airl_pkg::OP_REQUEST, 1'b1);
    wait_drained();

    // Random phases across several tunings and idle patterns
    write_all(airl_pkg::RST_START_RATE, airl_pkg::RST_MIN_RATE, airl_pkg::RST_CEILING_RATE,
              airl_pkg::RST_RAMP_RUN, airl_pkg::RST_FAIL_RESET_RUN,
              airl_pkg::RST_FRAMES_BEFORE_REST, airl_pkg::RST_REST_INTERVAL,
              airl_pkg::RST_REST_DURATION);
    random_events(85);
    wait_drained();

    write_all(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 8)),
              10'($urandom_range(20, 1023)), 16'($urandom_range(1, 4)),
              16'($urandom_range(3, 6)), 32'($urandom_range(1, 10)),
              16'($urandom_range(0, 3)), 16'($urandom_range(1, 4)));
    random_events(85);
    wait_drained();

    valid_idle_pct = 58;
    ready_idle_pct = 6;
    write_all(10'd1023, 10'd1023, 10'd1023, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
              16'hFFFF, 16'hFFFF);
    random_events(85);
    wait_drained();

    write_all(10'd1, 10'd1, 10'd1, 16'd1, 16'd3, 32'd1, 16'd0, 16'd1);
    random_events(85);
    wait_drained();

    // No idling; hold the receiver off so the input stalls behind it
    valid_idle_pct = 0;
    ready_idle_pct = 0;
    write_all(10'd0, 10'd0, 10'd0, 16'd0, 16'd0, 32'd0, 16'd0, 16'd0);
    random_events(85);
    hold_request = 1'b1;
    wait_drained();

    fail_pct = 45;
    write_all(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 30)),
              10'($urandom_range(1, 1023)), 16'($urandom_range(1, 8)),
              16'($urandom_range(3, 8)), 32'($urandom_range(1, 20)),
              16'($urandom_range(0, 6)), 16'($urandom_range(1, 6)));
    random_events(85);
    wait_drained();

    if (mismatches == 0) begin
      $display("adaptive_injection_rate_limiter_top_tb OK");
    end else begin
      $display("adaptive_injection_rate_limiter_top_tb NOT OK");
    end
    $finish;
  end

endmodule
